>>> src/fwe_pkg.sv
// Package for the handle queue with watermark events.
// Holds operation, status and register codes and the register bank type.
// No dependencies.
`timescale 1ns / 1ps

package fwe_pkg;

	localparam int MODE_W    = 2;
	localparam int STATUS_W  = 3;
	localparam int FILL_W    = 11;
	localparam int TH_W      = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DW    = 8;

	// Operation codes
	localparam logic [MODE_W-1:0] MODE_ENQ  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DEQ  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NULL   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_CLOSED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_READY_TH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_TH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ONCE     = 2'd3;

	typedef struct packed {
		logic [TH_W-1:0] ready_th;
		logic [TH_W-1:0] drain_th;
		logic            open;
		logic            once;
	} cfg_t;

endpackage

>>> src/fwe_ifs.sv
// Request and response channel interfaces of the handle queue.
// Depends on fwe_pkg for field widths.
`timescale 1ns / 1ps

interface fwe_req_if #(parameter int HANDLE_WIDTH = 32) ();
	import fwe_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [MODE_W-1:0]         mode;
	logic [HANDLE_WIDTH-1:0]   handle_in;
	logic                      handle_present;

	modport source (output valid, mode, handle_in, handle_present, input ready);
	modport sink   (input valid, mode, handle_in, handle_present, output ready);
endinterface

interface fwe_rsp_if #(parameter int HANDLE_WIDTH = 32) ();
	import fwe_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [STATUS_W-1:0]       status;
	logic [HANDLE_WIDTH-1:0]   handle_out;
	logic                      handle_out_valid;
	logic [FILL_W-1:0]         fill_count;
	logic                      ready_flag;
	logic                      drain_flag;
	logic                      ready_event;
	logic                      drain_event;

	modport source (output valid, status, handle_out, handle_out_valid, fill_count,
		ready_flag, drain_flag, ready_event, drain_event, input ready);
	modport sink   (input valid, status, handle_out, handle_out_valid, fill_count,
		ready_flag, drain_flag, ready_event, drain_event, output ready);
endinterface

>>> src/fifo_with_watermark_events.sv
// Top level of the handle queue with watermark events.
// Depends on fwe_pkg, fwe_ifs, fwe_store and fwe_core.
//
//   channel | direction | handshake      | payload
//   --------+-----------+----------------+---------------------------------------
//   req     | in        | valid / ready  | mode, handle_in, handle_present
//   rsp     | out       | valid / ready  | status, handle_out, handle_out_valid,
//           |           |                | fill_count, ready/drain flag and event
//   cfg     | in        | cfg_we         | cfg_idx, cfg_wdata
//
// One request per cycle while rsp is not stalled. A request is taken into the
// input register, then its result, with the registered head read, is registered.
// Reset clears pointers, fill count, flags and registers; the handle ring
// itself is not cleared and needs no clearing pass.
// A stalled rsp holds the output register; req ready drops only while both
// the input register and the output register are occupied.
`timescale 1ns / 1ps

module fifo_with_watermark_events
	import fwe_pkg::*;
#(
	parameter int QUEUE_DEPTH  = 1024,
	parameter int HANDLE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	fwe_req_if.sink                req,
	fwe_rsp_if.source              rsp,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_idx,
	input  logic [CFG_DW-1:0]      cfg_wdata
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	cfg_t cfg_q;

	logic                    valid_s1;
	logic [MODE_W-1:0]       mode_s1;
	logic [HANDLE_WIDTH-1:0] handle_s1;
	logic                    present_s1;

	logic                    valid_s2;
	logic [STATUS_W-1:0]     status_s2;
	logic [HANDLE_WIDTH-1:0] hout_s2;
	logic                    hvalid_s2;
	logic [FILL_W-1:0]       fill_s2;
	logic                    rflag_s2, dflag_s2, rev_s2, dev_s2;

	logic                    fire;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr, rd_addr;
	logic [HANDLE_WIDTH-1:0] wr_data, head_data;

	logic [STATUS_W-1:0]     status_c;
	logic [HANDLE_WIDTH-1:0] hout_c;
	logic                    hvalid_c;
	logic [FILL_W-1:0]       fill_c;
	logic                    rflag_c, dflag_c, rev_c, dev_c;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ready_th <= '0;
			cfg_q.drain_th <= '0;
			cfg_q.open     <= 1'b0;
			cfg_q.once     <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_READY_TH: cfg_q.ready_th <= cfg_wdata[TH_W-1:0];
				CFG_DRAIN_TH: cfg_q.drain_th <= cfg_wdata[TH_W-1:0];
				CFG_OPEN:     cfg_q.open     <= cfg_wdata[0];
				CFG_ONCE:     cfg_q.once     <= cfg_wdata[0];
			endcase
		end
	end

	// Process the held request when the output register is free or draining
	assign fire      = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || fire;

	// Input register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_s1    <= req.mode;
			handle_s1  <= req.handle_in;
			present_s1 <= req.handle_present;
		end
	end

	fwe_store #(
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.HANDLE_WIDTH (HANDLE_WIDTH)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (head_data)
	);

	fwe_core #(
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.HANDLE_WIDTH (HANDLE_WIDTH)
	) u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.fire             (fire),
		.mode             (mode_s1),
		.handle_in        (handle_s1),
		.handle_present   (present_s1),
		.cfg              (cfg_q),
		.head_data        (head_data),
		.wr_en            (wr_en),
		.wr_addr          (wr_addr),
		.wr_data          (wr_data),
		.rd_addr          (rd_addr),
		.status           (status_c),
		.handle_out       (hout_c),
		.handle_out_valid (hvalid_c),
		.fill_count       (fill_c),
		.ready_flag       (rflag_c),
		.drain_flag       (dflag_c),
		.ready_event      (rev_c),
		.drain_event      (dev_c)
	);

	// Output register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || rsp.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	// Output register: payload
	always_ff @(posedge clk) begin
		if (fire) begin
			status_s2 <= status_c;
			hout_s2   <= hout_c;
			hvalid_s2 <= hvalid_c;
			fill_s2   <= fill_c;
			rflag_s2  <= rflag_c;
			dflag_s2  <= dflag_c;
			rev_s2    <= rev_c;
			dev_s2    <= dev_c;
		end
	end

	assign rsp.valid            = valid_s2;
	assign rsp.status           = status_s2;
	assign rsp.handle_out       = hout_s2;
	assign rsp.handle_out_valid = hvalid_s2;
	assign rsp.fill_count       = fill_s2;
	assign rsp.ready_flag       = rflag_s2;
	assign rsp.drain_flag       = dflag_s2;
	assign rsp.ready_event      = rev_s2;
	assign rsp.drain_event      = dev_s2;

	a_fire_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> valid_s2)
		else $error("processed request lost before output register");

	a_no_write_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> fire)
		else $error("ring written without a processed request");

	a_event_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(rev_s2 && dev_s2))
		else $error("ready and drain events in one result");

endmodule

>>> src/fwe_store.sv
// Handle ring storage: one write port, one registered read port.
// Forwards a write that hits the address read in the same cycle.
`timescale 1ns / 1ps

module fwe_store #(
	parameter int QUEUE_DEPTH  = 1024,
	parameter int HANDLE_WIDTH = 32,
	localparam int AW = $clog2(QUEUE_DEPTH)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic [AW-1:0]           wr_addr,
	input  logic [HANDLE_WIDTH-1:0] wr_data,
	input  logic [AW-1:0]           rd_addr,
	output logic [HANDLE_WIDTH-1:0] rd_data
);

	logic [HANDLE_WIDTH-1:0] mem [QUEUE_DEPTH];
	logic [HANDLE_WIDTH-1:0] rd_data_q;
	logic [HANDLE_WIDTH-1:0] byp_data_q;
	logic                    byp_hit_q;

	// Write the tail entry, read the head entry every cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q  <= mem[rd_addr];
		byp_data_q <= wr_data;
	end

	// Mark a read that collided with a write of the same entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_hit_q <= 1'b0;
		end else begin
			byp_hit_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = byp_hit_q ? byp_data_q : rd_data_q;

endmodule

>>> src/fwe_core.sv
// Queue control: pointers, fill count, watermark flags and event logic.
// Depends on fwe_pkg; drives the write and read ports of fwe_store.
`timescale 1ns / 1ps

module fwe_core
	import fwe_pkg::*;
#(
	parameter int QUEUE_DEPTH  = 1024,
	parameter int HANDLE_WIDTH = 32,
	localparam int AW = $clog2(QUEUE_DEPTH)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    fire,
	input  logic [MODE_W-1:0]       mode,
	input  logic [HANDLE_WIDTH-1:0] handle_in,
	input  logic                    handle_present,
	input  cfg_t                    cfg,
	input  logic [HANDLE_WIDTH-1:0] head_data,
	output logic                    wr_en,
	output logic [AW-1:0]           wr_addr,
	output logic [HANDLE_WIDTH-1:0] wr_data,
	output logic [AW-1:0]           rd_addr,
	output logic [STATUS_W-1:0]     status,
	output logic [HANDLE_WIDTH-1:0] handle_out,
	output logic                    handle_out_valid,
	output logic [FILL_W-1:0]       fill_count,
	output logic                    ready_flag,
	output logic                    drain_flag,
	output logic                    ready_event,
	output logic                    drain_event
);

	localparam int CW   = $clog2(QUEUE_DEPTH + 1);
	localparam int CMPW = (CW > TH_W + 1) ? CW : TH_W + 1;

	logic [AW-1:0]   head_q, tail_q, head_inc, tail_inc;
	logic [CW-1:0]   count_q, count_n;
	logic            ready_q, drain_q, ready_n, drain_n;
	logic            is_full, is_empty, enq_ok, deq_ok;
	logic [CMPW-1:0] cnt_up, cnt_dn, mark, drain_lim;
	logic            hit;

	assign is_full  = (count_q == CW'(QUEUE_DEPTH));
	assign is_empty = (count_q == '0);
	assign head_inc = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;

	assign cnt_up    = CMPW'(count_q) + 1'b1;
	assign cnt_dn    = CMPW'(count_q) - 1'b1;
	assign mark      = CMPW'(cfg.ready_th) + 1'b1;
	assign drain_lim = CMPW'(cfg.drain_th);
	assign hit       = cfg.once ? (cnt_up == mark) : (cnt_up >= mark);

	// Decode the request against the current queue state
	always_comb begin
		status      = ST_OK;
		enq_ok      = 1'b0;
		deq_ok      = 1'b0;
		count_n     = count_q;
		ready_n     = ready_q;
		drain_n     = drain_q;
		ready_event = 1'b0;
		drain_event = 1'b0;
		handle_out_valid = 1'b0;
		unique case (mode)
			MODE_ENQ: begin
				priority if (!handle_present) begin
					status = ST_NULL;
				end else if (!cfg.open) begin
					status = ST_CLOSED;
				end else if (is_full) begin
					status = ST_FULL;
				end else begin
					enq_ok  = 1'b1;
					count_n = count_q + 1'b1;
					if (cnt_up > drain_lim) begin
						drain_n = 1'b0;
					end
					if (hit) begin
						ready_n     = 1'b1;
						ready_event = 1'b1;
					end
				end
			end
			MODE_DEQ: begin
				if (is_empty) begin
					status = ST_EMPTY;
				end else begin
					deq_ok           = 1'b1;
					handle_out_valid = 1'b1;
					count_n          = count_q - 1'b1;
					if (count_q == CW'(1)) begin
						ready_n = 1'b0;
					end
					if (cnt_dn <= drain_lim) begin
						drain_n     = 1'b1;
						drain_event = 1'b1;
					end
				end
			end
			MODE_PEEK: begin
				if (is_empty) begin
					status = ST_EMPTY;
				end else begin
					handle_out_valid = 1'b1;
				end
			end
			MODE_NONE: begin
				status = ST_OK;
			end
		endcase
	end

	assign handle_out = handle_out_valid ? head_data : '0;
	assign fill_count = FILL_W'(count_n);
	assign ready_flag = ready_n;
	assign drain_flag = drain_n;

	// Write the new tail entry; read ahead at the head the next request sees
	assign wr_en   = fire && enq_ok;
	assign wr_addr = tail_q;
	assign wr_data = handle_in;
	assign rd_addr = (fire && deq_ok) ? head_inc : head_q;

	// Advance the queue state on each processed request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			ready_q <= 1'b0;
			drain_q <= 1'b0;
		end else if (fire) begin
			count_q <= count_n;
			ready_q <= ready_n;
			drain_q <= drain_n;
			if (enq_ok) begin
				tail_q <= tail_inc;
			end
			if (deq_ok) begin
				head_q <= head_inc;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("fill count above queue depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(is_empty || is_full) |-> (head_q == tail_q))
		else $error("head and tail apart on empty or full queue");

	a_ready_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> !is_empty)
		else $error("ready flag set on empty queue");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && enq_ok) |=> (count_q == $past(count_q) + 1'b1))
		else $error("enqueue did not advance fill count");

endmodule

>>> dv/fwe_tb_pkg.sv
// Scoreboard for the handle queue testbench: request and result records and a
// class that predicts each result and checks it. Depends on fwe_pkg.
`timescale 1ns / 1ps

package fwe_tb_pkg;
	import fwe_pkg::*;

	localparam int QUEUE_DEPTH = 1024;
	localparam int HANDLE_W    = 32;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [HANDLE_W-1:0] handle;
		logic                present;
	} queue_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] handle_out;
		logic                handle_out_valid;
		logic [FILL_W-1:0]   fill_count;
		logic                ready_flag;
		logic                drain_flag;
		logic                ready_event;
		logic                drain_event;
	} queue_rsp_t;

	class handle_queue_scoreboard;
		logic [HANDLE_W-1:0] ring [QUEUE_DEPTH];
		int unsigned         head;
		int unsigned         tail;
		int unsigned         count;
		bit                  ready_bit;
		bit                  drain_bit;
		cfg_t                regs;
		queue_rsp_t          expected_q[$];
		int unsigned         mismatches;
		int unsigned         results_seen;

		function new();
			head         = 0;
			tail         = 0;
			count        = 0;
			ready_bit    = 1'b0;
			drain_bit    = 1'b0;
			regs         = '0;
			regs.once    = 1'b1;
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] data);
			case (idx)
				CFG_READY_TH: regs.ready_th = data;
				CFG_DRAIN_TH: regs.drain_th = data;
				CFG_OPEN:     regs.open     = data[0];
				CFG_ONCE:     regs.once     = data[0];
				default: ;
			endcase
		endfunction

		// Advance the queue state by one accepted request and store its result
		function void note_request(queue_req_t r);
			queue_rsp_t  e;
			int unsigned mark;
			e    = '0;
			mark = int'(regs.ready_th) + 1;
			case (r.mode)
				MODE_ENQ: begin
					if (!r.present) begin
						e.status = ST_NULL;
					end else if (!regs.open) begin
						e.status = ST_CLOSED;
					end else if (count >= QUEUE_DEPTH) begin
						e.status = ST_FULL;
					end else begin
						ring[tail] = r.handle;
						tail = (tail + 1) % QUEUE_DEPTH;
						count++;
						if (count > regs.drain_th)
							drain_bit = 1'b0;
						if (regs.once ? (count == mark) : (count >= mark)) begin
							ready_bit     = 1'b1;
							e.ready_event = 1'b1;
						end
					end
				end
				MODE_DEQ, MODE_PEEK: begin
					if (count == 0) begin
						e.status = ST_EMPTY;
					end else begin
						e.handle_out       = ring[head];
						e.handle_out_valid = 1'b1;
						if (r.mode == MODE_DEQ) begin
							head = (head + 1) % QUEUE_DEPTH;
							count--;
							if (count == 0)
								ready_bit = 1'b0;
							if (count <= regs.drain_th) begin
								drain_bit     = 1'b1;
								e.drain_event = 1'b1;
							end
						end
					end
				end
				default: ;
			endcase
			e.status     = e.status;
			e.fill_count = count[FILL_W-1:0];
			e.ready_flag = ready_bit;
			e.drain_flag = drain_bit;
			expected_q.push_back(e);
		endfunction

		// Compare one delivered result with the oldest stored one
		function void check_result(queue_rsp_t got);
			queue_rsp_t e;
			bit         bad;
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("queue check: result %0d arrived with nothing outstanding",
						results_seen);
				return;
			end
			e   = expected_q.pop_front();
			bad = (got.status !== e.status) || (got.handle_out !== e.handle_out) ||
				(got.handle_out_valid !== e.handle_out_valid) ||
				(got.fill_count !== e.fill_count) || (got.ready_flag !== e.ready_flag) ||
				(got.drain_flag !== e.drain_flag) || (got.ready_event !== e.ready_event) ||
				(got.drain_event !== e.drain_event);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("queue check: result %0d mismatch", results_seen);
					$display("  expected st=%0d h=%h hv=%b n=%0d rf=%b df=%b re=%b de=%b",
						e.status, e.handle_out, e.handle_out_valid, e.fill_count,
						e.ready_flag, e.drain_flag, e.ready_event, e.drain_event);
					$display("  actual   st=%0d h=%h hv=%b n=%0d rf=%b df=%b re=%b de=%b",
						got.status, got.handle_out, got.handle_out_valid, got.fill_count,
						got.ready_flag, got.drain_flag, got.ready_event, got.drain_event);
				end
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function bit failed();
			return (mismatches != 0) || (expected_q.size() != 0);
		endfunction
	endclass

endpackage

>>> dv/tb_fifo_with_watermark_events.sv
// Testbench top for the handle queue with watermark events: directed and random
// requests under several idling profiles, checked by the fwe_tb_pkg scoreboard.
// Depends on fwe_pkg, fwe_ifs, fwe_tb_pkg and the fifo_with_watermark_events RTL.
`timescale 1ns / 1ps

module tb_fifo_with_watermark_events;
	import fwe_pkg::*;
	import fwe_tb_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DW-1:0]    cfg_wdata;
	int unsigned          src_idle_pct;
	int unsigned          sink_stall_pct;

	handle_queue_scoreboard sb = new();

	fwe_req_if #(.HANDLE_WIDTH(HANDLE_W)) req ();
	fwe_rsp_if #(.HANDLE_WIDTH(HANDLE_W)) rsp ();

	fifo_with_watermark_events #(
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.HANDLE_WIDTH (HANDLE_W)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// Generate the clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Bound the run
	initial begin
		#4_000_000;
		$display("tb: failure");
		$finish;
	end

	// Take results, check them and stall at random
	initial begin
		queue_rsp_t got;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp.valid && rsp.ready) begin
				got.status           = rsp.status;
				got.handle_out       = rsp.handle_out;
				got.handle_out_valid = rsp.handle_out_valid;
				got.fill_count       = rsp.fill_count;
				got.ready_flag       = rsp.ready_flag;
				got.drain_flag       = rsp.drain_flag;
				got.ready_event      = rsp.ready_event;
				got.drain_event      = rsp.drain_event;
				sb.check_result(got);
			end
			rsp.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Send one request, idling first at random, and hold it until taken
	task automatic send_op(input logic [MODE_W-1:0] mode, input logic [HANDLE_W-1:0] handle,
		input logic present);
		queue_req_t r;
		r.mode    = mode;
		r.handle  = handle;
		r.present = present;
		while ($urandom_range(99) < src_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid          <= 1'b1;
		req.mode           <= mode;
		req.handle_in      <= handle;
		req.handle_present <= present;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sb.note_request(r);
	endtask

	// Drop the request line and wait until every result has come back
	task automatic hold_until_drained();
		req.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] data);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// Write all registers while the queue is idle
	task automatic set_config(input logic [TH_W-1:0] rth, input logic [TH_W-1:0] dth,
		input logic open_q, input logic once_q);
		hold_until_drained();
		put_reg(CFG_READY_TH, rth);
		put_reg(CFG_DRAIN_TH, dth);
		put_reg(CFG_OPEN, {{(CFG_DW-1){1'b0}}, open_q});
		put_reg(CFG_ONCE, {{(CFG_DW-1){1'b0}}, once_q});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Pick a fill level near one of the watermarks, or a low one
	function automatic int unsigned pick_level();
		case ($urandom_range(4))
			0: return int'(sb.regs.ready_th) + 1;
			1: return int'(sb.regs.ready_th);
			2: return int'(sb.regs.drain_th);
			3: return int'(sb.regs.drain_th) + 1;
			default: return $urandom_range(12);
		endcase
	endfunction

	// Random walk of the fill level around a moving target
	task automatic run_random_phase(input int unsigned n_ops);
		int unsigned         target;
		int unsigned         roll;
		logic [MODE_W-1:0]   mode;
		target = 0;
		for (int i = 0; i < n_ops; i++) begin
			if (i % 32 == 0)
				target = pick_level();
			if (i == n_ops / 2)
				hold_until_drained();
			roll = $urandom_range(99);
			if (roll < 6)
				mode = MODE_NONE;
			else if (roll < 16)
				mode = MODE_PEEK;
			else if (sb.count < target)
				mode = ($urandom_range(99) < 75) ? MODE_ENQ : MODE_DEQ;
			else
				mode = ($urandom_range(99) < 75) ? MODE_DEQ : MODE_ENQ;
			send_op(mode, $urandom(), $urandom_range(15) != 0);
		end
	endtask

	initial begin
		arst_n             <= 1'b0;
		req.valid          <= 1'b0;
		req.mode           <= MODE_ENQ;
		req.handle_in      <= '0;
		req.handle_present <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_idx            <= CFG_READY_TH;
		cfg_wdata          <= '0;
		src_idle_pct        = 0;
		sink_stall_pct      = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Queue closed after reset: null wins over closed, empty reads, unused mode
		send_op(MODE_ENQ, 32'h1234_5678, 1'b1);
		send_op(MODE_ENQ, 32'h1234_5678, 1'b0);
		send_op(MODE_DEQ, '0, 1'b1);
		send_op(MODE_PEEK, '0, 1'b1);
		send_op(MODE_NONE, 32'hFFFF_FFFF, 1'b1);

		// Single-shot ready event, zero handle, drain events down to empty
		set_config(8'd2, 8'd1, 1'b1, 1'b1);
		send_op(MODE_ENQ, 32'h0000_0000, 1'b1);
		send_op(MODE_ENQ, 32'hFFFF_FFFF, 1'b1);
		send_op(MODE_ENQ, 32'hA5A5_5A5A, 1'b1);
		send_op(MODE_ENQ, 32'h5A5A_A5A5, 1'b1);
		send_op(MODE_ENQ, 32'hFFFF_FFFF, 1'b0);
		send_op(MODE_PEEK, '0, 1'b0);
		send_op(MODE_NONE, '0, 1'b0);
		repeat (4) send_op(MODE_DEQ, 32'hFFFF_FFFF, 1'b1);
		send_op(MODE_DEQ, '0, 1'b1);

		// Level-style ready event at the lowest thresholds
		set_config(8'd0, 8'd0, 1'b1, 1'b0);
		send_op(MODE_ENQ, 32'h8000_0001, 1'b1);
		send_op(MODE_ENQ, 32'h7FFF_FFFE, 1'b1);
		send_op(MODE_DEQ, '0, 1'b1);
		send_op(MODE_DEQ, '0, 1'b1);

		// Fill to full at the highest thresholds, check refusal order, drain
		set_config(8'd255, 8'd255, 1'b1, 1'b1);
		repeat (QUEUE_DEPTH) send_op(MODE_ENQ, $urandom(), 1'b1);
		send_op(MODE_ENQ, $urandom(), 1'b1);
		send_op(MODE_ENQ, $urandom(), 1'b1);
		send_op(MODE_ENQ, $urandom(), 1'b0);
		set_config(8'd255, 8'd255, 1'b0, 1'b1);
		send_op(MODE_ENQ, $urandom(), 1'b1);
		send_op(MODE_PEEK, '0, 1'b1);
		send_op(MODE_NONE, '0, 1'b1);
		repeat (QUEUE_DEPTH + 1) send_op(MODE_DEQ, $urandom(), 1'($urandom_range(1)));

		// Random phases over idling profiles and register settings
		src_idle_pct = 0;  sink_stall_pct = 0;
		set_config(8'd3, 8'd1, 1'b1, 1'b1);
		run_random_phase(110);
		src_idle_pct = 57; sink_stall_pct = 0;
		set_config(8'd0, 8'd0, 1'b1, 1'b0);
		run_random_phase(110);
		src_idle_pct = 0;  sink_stall_pct = 57;
		set_config(8'd255, 8'd0, 1'b1, 1'b1);
		run_random_phase(100);
		src_idle_pct = 31; sink_stall_pct = 31;
		set_config(TH_W'($urandom_range(15)), TH_W'($urandom_range(15)), 1'b1,
			1'($urandom_range(1)));
		run_random_phase(110);
		src_idle_pct = 0;  sink_stall_pct = 0;
		set_config(TH_W'($urandom_range(15)), TH_W'($urandom_range(15)), 1'b0,
			1'($urandom_range(1)));
		run_random_phase(60);
		src_idle_pct = 57; sink_stall_pct = 0;
		set_config(TH_W'($urandom_range(20)), TH_W'($urandom_range(20)), 1'b1,
			1'($urandom_range(1)));
		run_random_phase(110);
		src_idle_pct = 0;  sink_stall_pct = 57;
		set_config(8'd0, 8'd255, 1'b1, 1'b1);
		run_random_phase(110);
		src_idle_pct = 31; sink_stall_pct = 31;
		set_config(TH_W'($urandom_range(20)), TH_W'($urandom_range(20)), 1'b1, 1'b0);
		run_random_phase(110);

		// Let the last results come back, then report
		hold_until_drained();
		repeat (8) @(posedge clk);
		if (!sb.failed())
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
